[hw/rtl/rvdec_pkg.sv]
// rvdec_pkg: types, opcode constants and mnemonic tables for the rv32i decoder
// no dependencies; imported by rv32_instruction_decoder_top
`default_nettype none

package rvdec_pkg;

  // beat payloads
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] fetch_pc;
  } in_beat_t;

  typedef enum logic [5:0] {
    MN_ADD     = 6'd0,
    MN_SLL     = 6'd1,
    MN_SLT     = 6'd2,
    MN_SLTU    = 6'd3,
    MN_XOR     = 6'd4,
    MN_SRL     = 6'd5,
    MN_OR      = 6'd6,
    MN_AND     = 6'd7,
    MN_SUB     = 6'd8,
    MN_SRA     = 6'd9,
    MN_ADDI    = 6'd10,
    MN_SLLI    = 6'd11,
    MN_SLTI    = 6'd12,
    MN_SLTIU   = 6'd13,
    MN_XORI    = 6'd14,
    MN_SRAI    = 6'd15,
    MN_SRLI    = 6'd16,
    MN_ORI     = 6'd17,
    MN_ANDI    = 6'd18,
    MN_LUI     = 6'd19,
    MN_AUIPC   = 6'd20,
    MN_JAL     = 6'd21,
    MN_JALR    = 6'd22,
    MN_BEQ     = 6'd23,
    MN_BNE     = 6'd24,
    MN_BLT     = 6'd25,
    MN_BGE     = 6'd26,
    MN_BLTU    = 6'd27,
    MN_BGEU    = 6'd28,
    MN_LB      = 6'd29,
    MN_LH      = 6'd30,
    MN_LW      = 6'd31,
    MN_LBU     = 6'd32,
    MN_LHU     = 6'd33,
    MN_SB      = 6'd34,
    MN_SH      = 6'd35,
    MN_SW      = 6'd36,
    MN_ECALL   = 6'd37,
    MN_EBREAK  = 6'd38,
    MN_UNKNOWN = 6'd39
  } mnem_e;

  typedef struct packed {
    logic               known;
    mnem_e              mnemonic;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        target;
  } out_beat_t;

  // major opcodes
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

  // funct fields
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [2:0] F3_ADD_SUB = 3'b000;
  localparam logic [2:0] F3_SLL     = 3'b001;
  localparam logic [2:0] F3_SR      = 3'b101;

  // exact system words
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  // mnemonic tables indexed by funct3
  typedef mnem_e mnem_tab_t [8];

  localparam mnem_tab_t OP_BASE_MN = '{MN_ADD, MN_SLL, MN_SLT, MN_SLTU,
                                       MN_XOR, MN_SRL, MN_OR, MN_AND};
  localparam mnem_tab_t OP_IMM_MN  = '{MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU,
                                       MN_XORI, MN_SRLI, MN_ORI, MN_ANDI};
  localparam mnem_tab_t BRANCH_MN  = '{MN_BEQ, MN_BNE, MN_UNKNOWN, MN_UNKNOWN,
                                       MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};
  localparam mnem_tab_t LOAD_MN    = '{MN_LB, MN_LH, MN_LW, MN_UNKNOWN,
                                       MN_LBU, MN_LHU, MN_UNKNOWN, MN_UNKNOWN};
  localparam mnem_tab_t STORE_MN   = '{MN_SB, MN_SH, MN_SW, MN_UNKNOWN,
                                       MN_UNKNOWN, MN_UNKNOWN, MN_UNKNOWN,
                                       MN_UNKNOWN};

endpackage

`default_nettype wire

[hw/rtl/rv32_instruction_decoder_top.sv]
// rv32_instruction_decoder_top: rv32i base set decoder, input register,
// decode logic and result register; depends on rvdec_pkg
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries one beat per instruction:
//   the raw word and the pc it was fetched from. Output channel
//   out_valid_o / out_ready_i carries one result beat per input beat, in
//   order: known flag, mnemonic code, rd, rs1, rs2, immediate and, for jal
//   and branches, the pc-relative target.
//   A beat taken is registered in the input register, decoded there by the
//   combinational decode logic and held in the result register, which
//   drives out_valid_o. Throughput is one beat per cycle while the receiver
//   keeps out_ready_i high; the single decode stage has one 32-bit target adder.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills; in_ready_o falls only once both are occupied.
//   Reset clears both valid flags; nothing else needs clearing.
//   Unrecognised words give known 0, mnemonic unknown and all other
//   fields zero.
`default_nettype none

module rv32_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_beat_o
);

  logic      s1_valid_q;
  in_beat_t  s1_beat_q;
  logic      out_valid_q;
  out_beat_t out_beat_q;
  out_beat_t dec_beat;
  logic      s2_ready;

  // handshake: each stage loads when empty or when its beat moves on
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_beat_q <= in_beat_i;
    end
  end

  // decode logic
  always_comb begin
    logic [31:0] w;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] i_imm;
    logic [31:0] s_imm;
    logic [31:0] b_imm;
    logic [31:0] j_imm;
    logic [31:0] u_imm;
    logic [31:0] imm;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic        use_tgt;
    mnem_e       mn;

    w     = s1_beat_q.instr_word;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    i_imm = {{20{w[31]}}, w[31:20]};
    s_imm = {{20{w[31]}}, w[31:25], w[11:7]};
    b_imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    j_imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    u_imm = {12'd0, w[31:12]};

    mn      = MN_UNKNOWN;
    imm     = '0;
    rd      = '0;
    rs1     = '0;
    rs2     = '0;
    use_tgt = 1'b0;

    case (opc)
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          mn = OP_BASE_MN[f3];
        end else if (f7 == F7_ALT && f3 == F3_ADD_SUB) begin
          mn = MN_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          mn = MN_SRA;
        end
        rd  = w[11:7];
        rs1 = w[19:15];
        rs2 = w[24:20];
      end
      OPC_OP_IMM: begin
        mn = OP_IMM_MN[f3];
        if (f3 == F3_SR && w[30]) begin
          mn = MN_SRAI;
        end
        // shifts carry shamt, the rest the I immediate
        if (f3 inside {F3_SLL, F3_SR}) begin
          imm = {27'd0, w[24:20]};
        end else begin
          imm = i_imm;
        end
        rd  = w[11:7];
        rs1 = w[19:15];
      end
      OPC_LUI: begin
        mn  = MN_LUI;
        imm = u_imm;
        rd  = w[11:7];
      end
      OPC_AUIPC: begin
        mn  = MN_AUIPC;
        imm = u_imm;
        rd  = w[11:7];
      end
      OPC_JAL: begin
        mn      = MN_JAL;
        imm     = j_imm;
        use_tgt = 1'b1;
        rd      = w[11:7];
      end
      OPC_JALR: begin
        mn  = MN_JALR;
        imm = i_imm;
        rd  = w[11:7];
        rs1 = w[19:15];
      end
      OPC_BRANCH: begin
        mn      = BRANCH_MN[f3];
        imm     = b_imm;
        use_tgt = 1'b1;
        rs1     = w[19:15];
        rs2     = w[24:20];
      end
      OPC_LOAD: begin
        mn  = LOAD_MN[f3];
        imm = i_imm;
        rd  = w[11:7];
        rs1 = w[19:15];
      end
      OPC_STORE: begin
        mn  = STORE_MN[f3];
        imm = s_imm;
        rs1 = w[19:15];
        rs2 = w[24:20];
      end
      OPC_SYSTEM: begin
        if (w == WORD_ECALL) begin
          mn = MN_ECALL;
        end else if (w == WORD_EBREAK) begin
          mn = MN_EBREAK;
        end
      end
      default: begin
        mn = MN_UNKNOWN;
      end
    endcase

    // unknown words leave every field at zero
    if (mn == MN_UNKNOWN) begin
      imm     = '0;
      rd      = '0;
      rs1     = '0;
      rs2     = '0;
      use_tgt = 1'b0;
    end

    dec_beat.known     = (mn != MN_UNKNOWN);
    dec_beat.mnemonic  = mn;
    dec_beat.dest_reg  = rd;
    dec_beat.src1_reg  = rs1;
    dec_beat.src2_reg  = rs2;
    dec_beat.immediate = $signed(imm);
    dec_beat.target    = use_tgt ? (s1_beat_q.fetch_pc + imm) : '0;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      out_beat_q <= dec_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // checks
  a_known_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.known == (out_beat_o.mnemonic != MN_UNKNOWN)))
    else $error("known flag disagrees with mnemonic");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_beat_o.known) |->
      (out_beat_o.immediate == 32'sd0 && out_beat_o.target == 32'd0 &&
       out_beat_o.dest_reg == 5'd0 && out_beat_o.src1_reg == 5'd0 &&
       out_beat_o.src2_reg == 5'd0))
    else $error("unknown word with non-zero fields");

  a_target_only_jumps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.target != 32'd0) |->
      (out_beat_o.mnemonic == MN_JAL || out_beat_o.mnemonic == MN_BEQ ||
       out_beat_o.mnemonic == MN_BNE || out_beat_o.mnemonic == MN_BLT ||
       out_beat_o.mnemonic == MN_BGE || out_beat_o.mnemonic == MN_BLTU ||
       out_beat_o.mnemonic == MN_BGEU))
    else $error("target set for a non pc-relative instruction");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_beat_q)))
    else $error("input register lost its beat under stall");

endmodule

`default_nettype wire

[dv/rv32_instruction_decoder_top_tb.sv]
`timescale 1ns / 100ps
// rv32_instruction_decoder_top_tb: self-checking bench for the rv32i decoder, driving
// instruction beats and comparing every result beat with a decode predictor
// depends on rvdec_pkg and rv32_instruction_decoder_top
module rv32_instruction_decoder_top_tb;
  import rvdec_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_BEATS = 1225;
  localparam int DRAIN_CYCLES = 8;

  // receiver stall behaviour, reselected each time the low byte of rx_count reaches FF
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } rx_mode_e;

  // one row of the directed table; res only used when typed is set
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t res;
  } dir_row_t;

  localparam out_beat_t UNK_RES = '{1'b0, MN_UNKNOWN, 5'd0, 5'd0, 5'd0, 32'sd0, 32'd0};

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  out_beat_t   pending_decodes [$];
  int unsigned error_count = 0;
  int unsigned burst_left  = 0;
  logic [31:0] rx_count    = '0;
  rx_mode_e    rx_mode     = RX_OPEN;

  // directed words: field extremes, rejected encodings, system words, corrected slips
  dir_row_t directed_rows [25] = '{
    '{'{32'h0000_0000, 32'h0000_0000}, 1'b1, UNK_RES},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, UNK_RES},
    '{'{WORD_ECALL, 32'h0000_0100}, 1'b1,
      '{1'b1, MN_ECALL, 5'd0, 5'd0, 5'd0, 32'sd0, 32'd0}},
    '{'{WORD_EBREAK, 32'h0000_0104}, 1'b1,
      '{1'b1, MN_EBREAK, 5'd0, 5'd0, 5'd0, 32'sd0, 32'd0}},
    '{'{32'h0020_0073, 32'h0000_0108}, 1'b1, UNK_RES},
    '{'{32'h4000_1033, 32'h0000_010C}, 1'b1, UNK_RES},
    '{'{32'h0200_0033, 32'h0000_0110}, 1'b1, UNK_RES},
    '{'{32'h0000_2063, 32'h0000_0114}, 1'b1, UNK_RES},
    '{'{32'h0000_3003, 32'h0000_0118}, 1'b1, UNK_RES},
    '{'{32'h0000_3023, 32'h0000_011C}, 1'b1, UNK_RES},
    '{'{32'hFFFF_F0B7, 32'h0000_0120}, 1'b1,
      '{1'b1, MN_LUI, 5'd1, 5'd0, 5'd0, 32'sh000F_FFFF, 32'd0}},
    '{'{32'h8000_006F, 32'h0000_0000}, 1'b1,
      '{1'b1, MN_JAL, 5'd0, 5'd0, 5'd0, 32'shFFF0_0000, 32'hFFF0_0000}},
    '{'{32'h7FFF_FFEF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{32'h01FF_8FB3, 32'h1234_5678}, 1'b0, '0},
    '{'{32'h40B5_0533, 32'h0000_2000}, 1'b0, '0},
    '{'{32'h40B5_5533, 32'h0000_2004}, 1'b0, '0},
    '{'{32'hFFF0_9093, 32'h0000_2008}, 1'b0, '0},
    '{'{32'h4030_D093, 32'h0000_200C}, 1'b0, '0},
    '{'{32'hBFF0_D093, 32'h0000_2010}, 1'b0, '0},
    '{'{32'h8000_0013, 32'h0000_2014}, 1'b0, '0},
    '{'{32'h1234_5297, 32'h8000_0000}, 1'b0, '0},
    '{'{32'hFFF0_80E7, 32'h0000_2018}, 1'b0, '0},
    '{'{32'hFFFF_FFE3, 32'h0000_0000}, 1'b0, '0},
    '{'{32'h7E00_0FE3, 32'hFFFF_F800}, 1'b0, '0},
    '{'{32'h00B5_20A3, 32'h0000_201C}, 1'b0, '0}
  };

  rv32_instruction_decoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // expected decode of one instruction beat
  function automatic out_beat_t decode_rv32(input in_beat_t beat);
    logic [31:0] w;
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [31:0] i_imm;
    out_beat_t   r;
    w     = beat.instr_word;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    i_imm = {{20{w[31]}}, w[31:20]};
    r          = '0;
    r.mnemonic = MN_UNKNOWN;
    case (opc)
      OPC_OP: begin
        if (f7 == F7_BASE) r.mnemonic = OP_BASE_MN[f3];
        else if (f7 == F7_ALT && f3 == F3_ADD_SUB) r.mnemonic = MN_SUB;
        else if (f7 == F7_ALT && f3 == F3_SR) r.mnemonic = MN_SRA;
        r.dest_reg = w[11:7];
        r.src1_reg = w[19:15];
        r.src2_reg = w[24:20];
      end
      OPC_OP_IMM: begin
        // bit 30 alone picks the arithmetic right shift
        r.mnemonic  = (f3 == F3_SR && w[30]) ? MN_SRAI : OP_IMM_MN[f3];
        r.immediate = (f3 == F3_SLL || f3 == F3_SR) ? {27'd0, w[24:20]} : i_imm;
        r.dest_reg  = w[11:7];
        r.src1_reg  = w[19:15];
      end
      OPC_LUI, OPC_AUIPC: begin
        r.mnemonic  = (opc == OPC_LUI) ? MN_LUI : MN_AUIPC;
        r.immediate = {12'd0, w[31:12]};
        r.dest_reg  = w[11:7];
      end
      OPC_JAL: begin
        r.mnemonic  = MN_JAL;
        r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r.target    = beat.fetch_pc + r.immediate;
        r.dest_reg  = w[11:7];
      end
      OPC_JALR: begin
        r.mnemonic  = MN_JALR;
        r.immediate = i_imm;
        r.dest_reg  = w[11:7];
        r.src1_reg  = w[19:15];
      end
      OPC_BRANCH: begin
        r.mnemonic  = BRANCH_MN[f3];
        r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        r.target    = beat.fetch_pc + r.immediate;
        r.src1_reg  = w[19:15];
        r.src2_reg  = w[24:20];
      end
      OPC_LOAD: begin
        r.mnemonic  = LOAD_MN[f3];
        r.immediate = i_imm;
        r.dest_reg  = w[11:7];
        r.src1_reg  = w[19:15];
      end
      OPC_STORE: begin
        r.mnemonic  = STORE_MN[f3];
        r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        r.src1_reg  = w[19:15];
        r.src2_reg  = w[24:20];
      end
      OPC_SYSTEM: begin
        if (w == WORD_ECALL) r.mnemonic = MN_ECALL;
        else if (w == WORD_EBREAK) r.mnemonic = MN_EBREAK;
      end
      default: ;
    endcase
    // unrecognised words carry nothing but the unknown code
    if (r.mnemonic == MN_UNKNOWN) begin
      r          = '0;
      r.mnemonic = MN_UNKNOWN;
    end else begin
      r.known = 1'b1;
    end
    return r;
  endfunction

  // mostly well-formed encodings with random fields, the rest near misses and noise
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [2:0]  f3;
    w  = $urandom;
    f3 = 3'($urandom_range(0, 5));
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        w[6:0] = OPC_OP;
        if ($urandom_range(0, 2) == 0) begin
          w[31:25] = F7_ALT;
          w[14:12] = $urandom_range(0, 1) ? F3_ADD_SUB : F3_SR;
        end else begin
          w[31:25] = F7_BASE;
        end
      end
      3, 4, 5: w[6:0] = OPC_OP_IMM;
      6:       w[6:0] = OPC_LUI;
      7:       w[6:0] = OPC_AUIPC;
      8:       w[6:0] = OPC_JAL;
      9:       w[6:0] = OPC_JALR;
      10, 11: begin
        w[6:0]   = OPC_BRANCH;
        w[14:12] = (f3 >= 3'd2) ? f3 + 3'd2 : f3;
      end
      12, 13: begin
        f3       = 3'($urandom_range(0, 4));
        w[6:0]   = OPC_LOAD;
        w[14:12] = (f3 >= 3'd3) ? f3 + 3'd1 : f3;
      end
      14: begin
        w[6:0]   = OPC_STORE;
        w[14:12] = 3'($urandom_range(0, 2));
      end
      15: w = $urandom_range(0, 1) ? WORD_ECALL : WORD_EBREAK;
      16: begin
        // known major opcode, random funct fields
        case ($urandom_range(0, 3))
          0:       w[6:0] = OPC_OP;
          1:       w[6:0] = OPC_BRANCH;
          2:       w[6:0] = OPC_LOAD;
          default: w[6:0] = OPC_STORE;
        endcase
      end
      17: w = ($urandom_range(0, 1) ? WORD_ECALL : WORD_EBREAK) ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    return w;
  endfunction

  // pc values cluster at both ends of the address space to exercise target wrap
  function automatic logic [31:0] rand_pc();
    case ($urandom_range(0, 7))
      0:       return 32'($urandom_range(0, 255));
      1:       return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (pending_decodes.size() == 0) begin
      $error("result beat with no instruction outstanding: %h", got);
      error_count++;
    end else begin
      want = pending_decodes.pop_front();
      check_field("known", 32'(want.known), 32'(got.known));
      check_field("mnemonic", 32'(want.mnemonic), 32'(got.mnemonic));
      check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
      check_field("src1_reg", 32'(want.src1_reg), 32'(got.src1_reg));
      check_field("src2_reg", 32'(want.src2_reg), 32'(got.src2_reg));
      check_field("immediate", want.immediate, got.immediate);
      check_field("target", want.target, got.target);
    end
  endtask

  // hold one instruction beat until taken, then queue its decode
  task automatic send_beat(input in_beat_t beat, input out_beat_t res);
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk_i); while (!in_ready);
    pending_decodes.push_back(res);
  endtask

  // burst bookkeeping, with a random gap, in three cases of four, once a burst runs out
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 39);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        in_beat  <= {$urandom, $urandom};
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_decodes.size() != 0);
  endtask

  // result side: check each beat taken, then pick the next ready level
  always @(posedge clk_i) begin
    if (out_valid && out_ready) check_result(out_beat);
    rx_count <= rx_count + 1;
    if (rx_count[7:0] == 8'hFF) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= rx_count[3];
    endcase
  end

  // stimulus: directed table, then random instruction beats
  initial begin
    in_beat_t beat;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed ?
                directed_rows[i].res : decode_rv32(directed_rows[i].beat));
      pace_sender();
    end
    wait_for_drain();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      beat.instr_word = rand_instr();
      beat.fetch_pc   = rand_pc();
      send_beat(beat, decode_rv32(beat));
      // one full drain half way through
      if (n == RANDOM_BEATS / 2) wait_for_drain();
      else pace_sender();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_decodes.size() != 0) begin
      $error("%0d result beats never arrived", pending_decodes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("rv32_instruction_decoder_top_tb: done, clean");
    end else begin
      $display("rv32_instruction_decoder_top_tb: done, errors");
    end
    $finish;
  end

  // watchdog against a stuck handshake
  initial begin
    #(4_000_000);
    $display("rv32_instruction_decoder_top_tb: done, errors");
    $finish;
  end

endmodule
